/* rtl/core/ryuv_pkg.sv */
`default_nettype none

package ryuv_pkg;

   // fixed field widths
   localparam int ADDR_W      = 25;
   localparam int CFG_W       = 13;
   localparam int SAMPLE_W    = 8;
   localparam int PLANE_W     = 2;
   localparam int CSR_INDEX_W = 1;

   // default frame limits handed to the top level
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
   localparam logic [CFG_W-1:0]       RST_FRAME_WIDTH  = 13'd1280;
   localparam logic [CFG_W-1:0]       RST_FRAME_HEIGHT = 13'd720;

   // plane codes
   localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

   // bt.601 integer coefficients and offsets
   localparam logic signed [8:0] Y_R = 9'sd66;
   localparam logic signed [8:0] Y_G = 9'sd129;
   localparam logic signed [8:0] Y_B = 9'sd25;
   localparam logic signed [8:0] U_R = -9'sd38;
   localparam logic signed [8:0] U_G = -9'sd74;
   localparam logic signed [8:0] U_B = 9'sd112;
   localparam logic signed [8:0] V_R = 9'sd112;
   localparam logic signed [8:0] V_G = -9'sd94;
   localparam logic signed [8:0] V_B = -9'sd18;
   localparam logic [SAMPLE_W-1:0] LUMA_OFFSET   = 8'd16;
   localparam logic [SAMPLE_W-1:0] CHROMA_OFFSET = 8'd128;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } ryuv_req_type;

   typedef struct packed {
      logic [PLANE_W-1:0]  plane;
      logic [ADDR_W-1:0]   byte_address;
      logic [SAMPLE_W-1:0] sample_value;
      logic                last_of_pixel;
      logic                frame_done;
   } ryuv_rsp_type;

   // one accepted pixel with its place in the frame
   typedef struct packed {
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [ADDR_W-1:0] luma_addr;
      logic [ADDR_W-1:0] area;
      logic [ADDR_W-1:0] chroma_off;
      logic              has_chroma;
      logic              frame_end;
   } ryuv_pix_type;

   // weighted sum, floor shift by 8, then offset, modulo 256
   function automatic logic [SAMPLE_W-1:0] conv_sample(
      input logic [7:0]          r,
      input logic [7:0]          g,
      input logic [7:0]          b,
      input logic signed [8:0]   cr,
      input logic signed [8:0]   cg,
      input logic signed [8:0]   cb,
      input logic [SAMPLE_W-1:0] offset
   );
      logic signed [17:0] sum;
      sum = cr * $signed({1'b0, r}) + cg * $signed({1'b0, g}) + cb * $signed({1'b0, b});
      return sum[15:8] + offset;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ryuv_chan_if.sv */
`default_nettype none

interface ryuv_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/ryuv_front.sv */
`default_nettype none

module ryuv_front import ryuv_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  eff_width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] eff_height,
   ryuv_chan_if.sink req,
   input  wire logic pix_take,
   output logic      pix_vld,
   output ryuv_pix_type pix
);

   localparam int EW  = $clog2(MAX_WIDTH+1);
   localparam int EH  = $clog2(MAX_HEIGHT+1);
   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LW  = CW + RW;
   localparam int CHW = (LW > 2) ? LW - 2 : 1;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [LW-1:0]  luma_ff, luma_in;
   logic [CHW-1:0] chroma_ff, chroma_in;
   logic           pix_vld_ff, pix_vld_in;
   ryuv_pix_type   pix_ff, pix_in;

   logic              accept;
   logic              row_end;
   logic              frame_end;
   logic              has_chroma;
   logic [EW+EH-1:0]  area;

   assign req.ready = !pix_vld_ff || pix_take;
   assign accept    = req.valid && req.ready;

   // position of this pixel in the frame
   assign row_end    = EW'(col_ff) >= eff_width - EW'(1);
   assign frame_end  = row_end && (EH'(row_ff) >= eff_height - EH'(1));
   assign has_chroma = !row_ff[0] && !col_ff[0];
   assign area       = (EW+EH)'(eff_width) * (EW+EH)'(eff_height);

   // raster counters
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      luma_in   = luma_ff;
      chroma_in = chroma_ff;
      if (accept) begin
         luma_in   = luma_ff + LW'(1);
         chroma_in = has_chroma ? chroma_ff + CHW'(1) : chroma_ff;
         if (frame_end) begin
            col_in    = '0;
            row_in    = '0;
            luma_in   = '0;
            chroma_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // pixel register
   always_comb begin
      pix_in            = pix_ff;
      pix_vld_in        = pix_vld_ff;
      if (accept) begin
         pix_in.red        = req.payload.red;
         pix_in.green      = req.payload.green;
         pix_in.blue       = req.payload.blue;
         pix_in.luma_addr  = ADDR_W'(luma_ff);
         pix_in.area       = ADDR_W'(area);
         pix_in.chroma_off = ADDR_W'(chroma_ff);
         pix_in.has_chroma = has_chroma;
         pix_in.frame_end  = frame_end;
         pix_vld_in        = 1'b1;
      end else if (pix_take) begin
         pix_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         luma_ff    <= '0;
         chroma_ff  <= '0;
         pix_vld_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         luma_ff    <= luma_in;
         chroma_ff  <= chroma_in;
         pix_vld_ff <= pix_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix_vld = pix_vld_ff;
   assign pix     = pix_ff;

endmodule

`default_nettype wire

/* rtl/core/ryuv_seq.sv */
`default_nettype none

module ryuv_seq import ryuv_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic pix_vld,
   input  wire ryuv_pix_type pix,
   output logic      pix_take,
   ryuv_chan_if.source rsp
);

   logic                seq_vld_ff, seq_vld_in;
   logic [PLANE_W-1:0]  plane_ff, plane_in;
   logic [SAMPLE_W-1:0] y_ff, u_ff, v_ff;
   logic [ADDR_W-1:0]   luma_addr_ff, u_addr_ff, v_addr_ff;
   logic                has_chroma_ff, frame_end_ff;
   logic                out_vld_ff, out_vld_in;
   ryuv_rsp_type        out_ff;

   logic                seq_load;
   logic                out_load;
   logic                seq_done;
   ryuv_rsp_type        cur;

   // pick the pending result of the held pixel
   always_comb begin
      cur.plane = plane_ff;
      case (plane_ff)
         PLANE_Y: begin
            cur.byte_address  = luma_addr_ff;
            cur.sample_value  = y_ff;
            cur.last_of_pixel = !has_chroma_ff;
         end
         PLANE_U: begin
            cur.byte_address  = u_addr_ff;
            cur.sample_value  = u_ff;
            cur.last_of_pixel = 1'b0;
         end
         PLANE_V: begin
            cur.byte_address  = v_addr_ff;
            cur.sample_value  = v_ff;
            cur.last_of_pixel = 1'b1;
         end
         default: begin
            cur.byte_address  = luma_addr_ff;
            cur.sample_value  = y_ff;
            cur.last_of_pixel = 1'b1;
         end
      endcase
      cur.frame_done = cur.last_of_pixel && frame_end_ff;
   end

   // handshake between pixel, sequencer and output register
   assign out_load = seq_vld_ff && (!out_vld_ff || rsp.ready);
   assign seq_done = out_load && cur.last_of_pixel;
   assign seq_load = pix_vld && (!seq_vld_ff || seq_done);
   assign pix_take = seq_load;

   always_comb begin
      plane_in   = plane_ff;
      seq_vld_in = seq_vld_ff;
      if (seq_load) begin
         plane_in   = PLANE_Y;
         seq_vld_in = 1'b1;
      end else if (out_load) begin
         case (plane_ff)
            PLANE_Y: plane_in = PLANE_U;
            PLANE_U: plane_in = PLANE_V;
            default: plane_in = PLANE_Y;
         endcase
         if (seq_done) begin
            seq_vld_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_vld_ff <= 1'b0;
         plane_ff   <= PLANE_Y;
         out_vld_ff <= 1'b0;
      end else begin
         seq_vld_ff <= seq_vld_in;
         plane_ff   <= plane_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // conversion and plane addresses of a new pixel
   always_ff @(posedge clock) begin
      if (seq_load) begin
         y_ff          <= conv_sample(pix.red, pix.green, pix.blue, Y_R, Y_G, Y_B, LUMA_OFFSET);
         u_ff          <= conv_sample(pix.red, pix.green, pix.blue, U_R, U_G, U_B,
                                      CHROMA_OFFSET);
         v_ff          <= conv_sample(pix.red, pix.green, pix.blue, V_R, V_G, V_B,
                                      CHROMA_OFFSET);
         luma_addr_ff  <= pix.luma_addr;
         u_addr_ff     <= pix.area + pix.chroma_off;
         v_addr_ff     <= pix.area + (pix.area >> 2) + pix.chroma_off;
         has_chroma_ff <= pix.has_chroma;
         frame_end_ff  <= pix.frame_end;
      end
      if (out_load) begin
         out_ff <= cur;
      end
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

endmodule

`default_nettype wire

/* rtl/core/rgba_to_yuv420_planar.sv */
// rgba_to_yuv420_planar: rgb pixels in raster order to planar yuv 4:2:0 bytes
//
// req_if carries one pixel (red, green, blue) per request; rsp_if carries one
// output byte per request with its plane, byte address in the planar buffer,
// and last_of_pixel / frame_done marks. Every pixel gives a Y byte; pixels on
// even rows and even columns also give a U byte and then a V byte.
// Frame size is set through the csr_ port (index 0 width, 1 height); the user
// must write it while no pixel is in flight, which the block does not enforce.
// A request passes the pixel register, the sequencer and the output register.
// Throughput: one request per cycle on pixels with only a Y byte while the
// receiver does not stall; a pixel that also gives chroma holds the sequencer
// until its V byte is loaded, set by the single output register that hands out
// one byte per cycle while the receiver takes them.
// Reset clears the raster counters to the top left corner, empties the
// pipeline and loads a 1280x720 frame size.
// When the receiver stalls, the output register holds its byte, the sequencer
// and pixel register fill, and req_if.ready drops; nothing is lost.

`default_nettype none

module rgba_to_yuv420_planar import ryuv_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ryuv_chan_if.sink                   req_if,
   ryuv_chan_if.source                 rsp_if,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_write_data
);

   localparam int EW = $clog2(MAX_WIDTH+1);
   localparam int EH = $clog2(MAX_HEIGHT+1);

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [CFG_W:0]   width_sat;
   logic [CFG_W:0]   height_sat;
   logic [EW-1:0]    eff_width;
   logic [EH-1:0]    eff_height;
   logic             pix_vld;
   logic             pix_take;
   ryuv_pix_type     pix;

   // configuration registers
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            REG_FRAME_HEIGHT: frame_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // saturate the frame size, width rounded down to even
   always_comb begin
      width_sat = {1'b0, frame_width_ff};
      if (width_sat < (CFG_W+1)'(2)) begin
         width_sat = (CFG_W+1)'(2);
      end else if (width_sat > (CFG_W+1)'(MAX_WIDTH)) begin
         width_sat = (CFG_W+1)'(MAX_WIDTH);
      end
      width_sat[0] = 1'b0;
      height_sat = {1'b0, frame_height_ff};
      if (height_sat < (CFG_W+1)'(1)) begin
         height_sat = (CFG_W+1)'(1);
      end else if (height_sat > (CFG_W+1)'(MAX_HEIGHT)) begin
         height_sat = (CFG_W+1)'(MAX_HEIGHT);
      end
   end

   assign eff_width  = EW'(width_sat);
   assign eff_height = EH'(height_sat);

   ryuv_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .req        (req_if),
      .pix_take   (pix_take),
      .pix_vld    (pix_vld),
      .pix        (pix)
   );

   ryuv_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .pix_vld  (pix_vld),
      .pix      (pix),
      .pix_take (pix_take),
      .rsp      (rsp_if)
   );

`ifndef SYNTHESIS
   // the pipeline is empty right after reset
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_if.ready)
      else $error("request not ready after reset");

   // a U byte is never the last of its pixel
   a_u_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.payload.plane == PLANE_U) |->
         (!rsp_if.payload.last_of_pixel && !rsp_if.payload.frame_done))
      else $error("U byte marked as last");

   // a V byte always closes its pixel, frame end only on a closing byte
   a_v_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.payload.plane == PLANE_V || rsp_if.payload.frame_done)) |->
         rsp_if.payload.last_of_pixel)
      else $error("pixel close mark missing");

   // an accepted U byte is followed by its V byte
   a_u_then_v: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.payload.plane == PLANE_U) |=>
         (rsp_if.valid && rsp_if.payload.plane == PLANE_V))
      else $error("V byte does not follow U byte");
`endif

endmodule

`default_nettype wire

/* verif/rgba_to_yuv420_planar_test.sv */
module rgba_to_yuv420_planar_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ryuv_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 400;
   localparam int SHOWN_ERRORS  = 10;

   typedef enum logic {FEED_PIXEL, FEED_CSR} feed_kind_type;
   typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_BLOCKED} sink_mode_type;

   // one pending step for the driver: a pixel request or a register write
   typedef struct {
      feed_kind_type          kind;
      bit                     wait_drain;
      ryuv_req_type           pixel;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CFG_W-1:0]       reg_value;
   } feed_entry_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_write_data;

   ryuv_chan_if #(.payload_type(ryuv_req_type)) pixel_ch ();
   ryuv_chan_if #(.payload_type(ryuv_rsp_type)) byte_ch ();

   rgba_to_yuv420_planar DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (pixel_ch),
      .rsp_if           (byte_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   feed_entry_type feed_q[$];
   ryuv_rsp_type   yuv_bytes_due[$];

   // converter state as the block should hold it
   logic [CFG_W-1:0] frame_w_reg = RST_FRAME_WIDTH;
   logic [CFG_W-1:0] frame_h_reg = RST_FRAME_HEIGHT;
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   int unsigned      luma_next = 0;
   int unsigned      chroma_next = 0;

   int  pixels_queued = 0;
   int  pixels_taken = 0;
   int  bytes_checked = 0;
   int  chroma_pixels = 0;
   int  frame_ends = 0;
   int  csr_writes = 0;
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  pixel_taken_last = 1'b0;

   // sender and receiver pacing
   int            settle_count = 0;
   int            burst_left = 0;
   int            gap_left = 0;
   sink_mode_type sink_mode = SINK_OPEN;
   int            mode_left = 0;
   int            sink_tick = 0;
   int            block_left = 0;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= SHOWN_ERRORS) begin
         $display("%s", msg);
      end
   endtask

   // weighted sum, floor divide by 256, add offset, keep the low byte
   function automatic logic [7:0] scale_sum(input int sum, input int bias);
      int q;
      q = sum >>> 8;
      return 8'(q + bias);
   endfunction

   // expected bytes for one accepted pixel, then advance the raster position
   task automatic convert_pixel(input ryuv_req_type px);
      int unsigned  w, h, area, v_base;
      int           r, g, b;
      bit           row_end, frame_end, has_chroma;
      ryuv_rsp_type s;
      w = frame_w_reg;
      if (w < 2) w = 2;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      w = w & ~32'd1;
      h = frame_h_reg;
      if (h < 1) h = 1;
      if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
      area = w * h;
      v_base = area + area / 4;
      row_end = col_pos >= w - 1;
      frame_end = row_end && row_pos >= h - 1;
      has_chroma = (row_pos % 2 == 0) && (col_pos % 2 == 0);
      r = px.red;
      g = px.green;
      b = px.blue;

      s.plane = PLANE_Y;
      s.byte_address = ADDR_W'(luma_next);
      s.sample_value = scale_sum(66 * r + 129 * g + 25 * b, 16);
      s.last_of_pixel = !has_chroma;
      s.frame_done = !has_chroma && frame_end;
      yuv_bytes_due.push_back(s);
      luma_next++;

      if (has_chroma) begin
         s.plane = PLANE_U;
         s.byte_address = ADDR_W'(area + chroma_next);
         s.sample_value = scale_sum(-38 * r - 74 * g + 112 * b, 128);
         s.last_of_pixel = 1'b0;
         s.frame_done = 1'b0;
         yuv_bytes_due.push_back(s);
         s.plane = PLANE_V;
         s.byte_address = ADDR_W'(v_base + chroma_next);
         s.sample_value = scale_sum(112 * r - 94 * g - 18 * b, 128);
         s.last_of_pixel = 1'b1;
         s.frame_done = frame_end;
         yuv_bytes_due.push_back(s);
         chroma_next++;
         chroma_pixels++;
      end

      if (frame_end) begin
         col_pos = 0;
         row_pos = 0;
         luma_next = 0;
         chroma_next = 0;
         frame_ends++;
      end else if (row_end) begin
         col_pos = 0;
         row_pos++;
      end else begin
         col_pos++;
      end
   endtask

   task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input bit drain);
      feed_entry_type e;
      e.kind = FEED_PIXEL;
      e.wait_drain = drain;
      e.pixel.red = r;
      e.pixel.green = g;
      e.pixel.blue = b;
      e.reg_index = REG_FRAME_WIDTH;
      e.reg_value = '0;
      feed_q.push_back(e);
      pixels_queued++;
   endtask

   task automatic queue_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
      feed_entry_type e;
      e.kind = FEED_CSR;
      e.wait_drain = 1'b1;
      e.pixel = '0;
      e.reg_index = idx;
      e.reg_value = value;
      feed_q.push_back(e);
   endtask

   // channel value, leaning on the extremes now and then
   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // pixel requests in bursts, register writes only once the block is idle
   always @(negedge clock) begin : drive_pixels
      feed_entry_type entry;
      logic           hold_valid;
      logic           raise_we;
      hold_valid = pixel_ch.valid && !pixel_taken_last;
      raise_we = 1'b0;
      if (hold_valid || yuv_bytes_due.size() != 0) settle_count = 0;
      else settle_count++;
      if (!reset && !hold_valid && feed_q.size() != 0) begin
         if (feed_q[0].kind == FEED_CSR) begin
            if (settle_count >= SETTLE_CYCLES) begin
               entry = feed_q.pop_front();
               raise_we = 1'b1;
               csr_index <= entry.reg_index;
               csr_write_data <= entry.reg_value;
            end
         end else if (gap_left != 0) begin
            gap_left--;
         end else if (!feed_q[0].wait_drain || yuv_bytes_due.size() == 0) begin
            entry = feed_q.pop_front();
            hold_valid = 1'b1;
            pixel_ch.payload <= entry.pixel;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
      pixel_ch.valid <= hold_valid;
      csr_write_enable <= raise_we;
   end

   // receiver back-pressure, switching between a few stall patterns
   always @(negedge clock) begin : drive_sink
      if (mode_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(30, 240);
      end else begin
         mode_left--;
      end
      sink_tick++;
      case (sink_mode)
         SINK_OPEN:     byte_ch.ready <= 1'b1;
         SINK_RANDOM:   byte_ch.ready <= ($urandom_range(0, 2) != 0);
         SINK_PERIODIC: byte_ch.ready <= (sink_tick % 4 == 0);
         default: begin
            if (block_left != 0) begin
               block_left--;
               byte_ch.ready <= 1'b0;
            end else begin
               block_left = $urandom_range(0, 24);
               byte_ch.ready <= 1'b1;
            end
         end
      endcase
   end

   // track register writes and pixel requests, check every output byte in order
   always @(posedge clock) begin : check_bytes
      ryuv_rsp_type got;
      ryuv_rsp_type want;
      pixel_taken_last <= pixel_ch.valid && pixel_ch.ready;
      if (!reset) begin
         if (csr_write_enable) begin
            csr_writes++;
            if (csr_index == REG_FRAME_WIDTH) frame_w_reg = csr_write_data;
            else frame_h_reg = csr_write_data;
         end
         if (pixel_ch.valid && pixel_ch.ready) begin
            pixels_taken++;
            convert_pixel(pixel_ch.payload);
         end
         if (byte_ch.valid && byte_ch.ready) begin
            got = byte_ch.payload;
            if (yuv_bytes_due.size() == 0) begin
               report_error($sformatf("error: unexpected byte plane %0d addr 0x%h value 0x%h",
                                      got.plane, got.byte_address, got.sample_value));
            end else begin
               want = yuv_bytes_due.pop_front();
               bytes_checked++;
               if (got.plane !== want.plane || got.byte_address !== want.byte_address ||
                   got.sample_value !== want.sample_value ||
                   got.last_of_pixel !== want.last_of_pixel ||
                   got.frame_done !== want.frame_done) begin
                  report_error($sformatf(
                     "error: byte %0d expected plane %0d addr 0x%h value 0x%h last %b done %b",
                     bytes_checked, want.plane, want.byte_address, want.sample_value,
                     want.last_of_pixel, want.frame_done));
                  if (error_count <= SHOWN_ERRORS) begin
                     $display("       got      plane %0d addr 0x%h value 0x%h last %b done %b",
                              got.plane, got.byte_address, got.sample_value,
                              got.last_of_pixel, got.frame_done);
                  end
               end
            end
         end
         if (csr_write_enable || (pixel_ch.valid && pixel_ch.ready) ||
             (byte_ch.valid && byte_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("rgba_to_yuv420_planar: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic [23:0]      corner_colors [12];
      logic [CFG_W-1:0] w_pick;
      logic [CFG_W-1:0] h_pick;
      int               random_count;
      int               phase;
      int               n;
      bit               drain;

      reset = 1'b1;
      pixel_ch.valid = 1'b0;
      pixel_ch.payload = '0;
      byte_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_FRAME_WIDTH;
      csr_write_data = '0;

      // reset frame size: first pixels land at the top left of a 1280x720 frame
      queue_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);

      // 4x3 frame entered mid-row, odd height puts chroma on the last row
      queue_csr(REG_FRAME_WIDTH, 13'd4);
      queue_csr(REG_FRAME_HEIGHT, 13'd3);
      corner_colors = '{24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080,
                        24'h010203, 24'hFEFDFC, 24'hFF0000, 24'h000000, 24'hFFFFFF, 24'h1080F0};
      foreach (corner_colors[i]) begin
         queue_pixel(corner_colors[i][23:16], corner_colors[i][15:8], corner_colors[i][7:0],
                     1'b0);
      end

      // shrink mid-frame so the counters sit past the new row and frame end
      queue_csr(REG_FRAME_WIDTH, 13'd6);
      queue_csr(REG_FRAME_HEIGHT, 13'd2);
      for (int i = 0; i < 8; i++) begin
         queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
      end
      queue_csr(REG_FRAME_WIDTH, 13'd2);
      queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);

      // random phases: extreme sizes first, then mostly small frames
      random_count = 0;
      phase = 0;
      while (random_count < RANDOM_PIXELS) begin
         case (phase)
            0: begin w_pick = 13'd0;    h_pick = 13'd0;    end
            1: begin w_pick = 13'd8191; h_pick = 13'd8191; end
            2: begin w_pick = 13'd1;    h_pick = 13'd1;    end
            3: begin w_pick = 13'd4096; h_pick = 13'd4096; end
            4: begin w_pick = 13'd4097; h_pick = 13'd4095; end
            5: begin w_pick = 13'd5;    h_pick = 13'd3;    end
            6: begin w_pick = 13'd2;    h_pick = 13'd1;    end
            default: begin
               case ($urandom_range(0, 9))
                  0:       w_pick = 13'($urandom_range(0, 8191));
                  1:       w_pick = 13'($urandom_range(0, 7) * 2 + 1);
                  2:       w_pick = 13'($urandom_range(4090, 4100));
                  default: w_pick = 13'($urandom_range(1, 8) * 2);
               endcase
               case ($urandom_range(0, 7))
                  0:       h_pick = 13'($urandom_range(0, 8191));
                  1:       h_pick = 13'($urandom_range(4094, 4098));
                  default: h_pick = 13'($urandom_range(1, 6));
               endcase
            end
         endcase
         if (phase < 7 || $urandom_range(0, 4) != 0) queue_csr(REG_FRAME_WIDTH, w_pick);
         if (phase < 7 || $urandom_range(0, 4) != 0) queue_csr(REG_FRAME_HEIGHT, h_pick);
         n = $urandom_range(8, 40);
         for (int i = 0; i < n; i++) begin
            // hold the sender mid-phase until every pending byte is out
            drain = (i == n / 2 && (phase == 0 || $urandom_range(0, 1) == 0)) ||
                    $urandom_range(0, 63) == 0;
            queue_pixel(rand_channel(), rand_channel(), rand_channel(), drain);
         end
         random_count += n;
         phase++;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pixels_taken != pixels_queued || yuv_bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (yuv_bytes_due.size() != 0) begin
         report_error($sformatf("error: %0d expected bytes never arrived",
                                yuv_bytes_due.size()));
      end

      $display("covered %0d pixels (%0d with chroma), %0d bytes checked, %0d frame ends,",
               pixels_taken, chroma_pixels, bytes_checked, frame_ends);
      $display("%0d frame size writes across %0d size settings, %0d errors",
               csr_writes, phase + 3, error_count);
      if (error_count == 0) begin
         $display("rgba_to_yuv420_planar: match");
      end else begin
         $display("rgba_to_yuv420_planar: mismatch");
      end
      $finish;
   end

endmodule
